### design/psr_pkg.sv
package psr_pkg;

	// Widths of the time base and of the configuration words
	localparam int TIME_W = 32;
	localparam int CFG_W  = 16;
	localparam int GYRO_W = 15;

	// Speed numerator and the serial divider built around it
	localparam int          NUM_W     = 14;
	localparam logic [13:0] SPEED_NUM = 14'd10000;
	localparam int          QUO_W     = NUM_W;
	localparam int          CNT_W     = $clog2(QUO_W + 1);

	// Register indexes on the configuration port
	localparam logic [2:0] REG_MIN_GAP  = 3'd0;
	localparam logic [2:0] REG_STALL    = 3'd1;
	localparam logic [2:0] REG_UPDATE   = 3'd2;
	localparam logic [2:0] REG_GYRO_LIM = 3'd3;
	localparam logic [2:0] REG_SLOW_IV  = 3'd4;
	localparam logic [2:0] REG_FAST_IV  = 3'd5;

	// Reset values of the registers
	localparam logic [CFG_W-1:0]  RST_MIN_GAP  = 16'd30;
	localparam logic [CFG_W-1:0]  RST_STALL    = 16'd3000;
	localparam logic [CFG_W-1:0]  RST_UPDATE   = 16'd100;
	localparam logic [GYRO_W-1:0] RST_GYRO_LIM = 15'd180;
	localparam logic [CFG_W-1:0]  RST_SLOW_IV  = 16'd50;
	localparam logic [CFG_W-1:0]  RST_FAST_IV  = 16'd200;

	// Request to the divider
	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] divisor;
	} psr_div_req_t;

	// Status and result from the divider
	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic             rem_nz;
	} psr_div_res_t;

endpackage

### design/pulse_speed_pwm_regulator_unit.sv
// Channel  | Direction | Handshake            | Beat
// ---------+-----------+----------------------+---------------------------------------
// in       | to block  | in_valid / in_stall  | one millisecond tick: pulse, pot, gyros
// out      | from block| out_valid / out_stall| one motor update: duty, speed, pixels
// cfg      | to block  | cfg_write            | register index and 16-bit data
//
// A tick without a motor update leaves the block ready for the next tick. A tick with
// an update passes through the accept, 14 steps of the bit-serial speed divider, the
// hand-over of its result and the step of the duty that loads the output register.
// The output register holds a beat while out_stall is high; the next tick is taken
// meanwhile, and only a following update waits for the register to free up.
// Reset (arst_n, asynchronous) clears all time stamps, the period and the duty.
module pulse_speed_pwm_regulator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        pulse_seen,
	input  logic [9:0]  pot_sample,
	input  logic signed [15:0] pitch_rate,
	input  logic signed [15:0] yaw_rate,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pwm_duty,
	output logic [8:0]  speed_units,
	output logic [7:0]  request_level,
	output logic [7:0]  target_speed,
	output logic        gyro_correcting,
	output logic [5:0]  duty_pixel,
	output logic [4:0]  speed_pixel,
	output logic [5:0]  request_pixel,
	output logic [2:0]  tilt_column,
	output logic [2:0]  tilt_row,
	output logic [1:0]  duty_colour
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	localparam logic [1:0] COL_RED  = 2'd0;
	localparam logic [1:0] COL_GYRO = 2'd1;
	localparam logic [1:0] COL_FULL = 2'd2;

	localparam int TW = psr_pkg::TIME_W;
	localparam int CW = psr_pkg::CFG_W;
	localparam int QW = psr_pkg::QUO_W;

	// Map a gyro rate to a cell: clamp(3 - trunc(rate / 60), 0, 7)
	function automatic logic [2:0] tilt_of(input logic signed [15:0] r);
		logic [2:0] t;
		if (r >= 16'sd180)       t = 3'd0;
		else if (r >= 16'sd120)  t = 3'd1;
		else if (r >= 16'sd60)   t = 3'd2;
		else if (r > -16'sd60)   t = 3'd3;
		else if (r > -16'sd120)  t = 3'd4;
		else if (r > -16'sd180)  t = 3'd5;
		else if (r > -16'sd240)  t = 3'd6;
		else                     t = 3'd7;
		return t;
	endfunction

	state_t state_q;

	// configuration registers
	logic [CW-1:0]             min_gap_q, stall_q, upd_period_q, slow_iv_q, fast_iv_q;
	logic [psr_pkg::GYRO_W-1:0] gyro_lim_q;

	// time base and measurement state
	logic [TW-1:0] now_q, last_pulse_q, period_q, last_upd_q, last_adj_q;
	logic [7:0]    duty_q;

	// item captured at accept
	logic [TW-1:0]      cur_q;
	logic [7:0]         req_q;
	logic signed [15:0] pitch_q, yaw_q;
	logic               yaw_big_q;
	logic               per_zero_q;

	// output register
	logic       out_valid_q;
	logic [7:0] pwm_duty_q, request_level_q, target_speed_q;
	logic [8:0] speed_units_q;
	logic       gyro_correcting_q;
	logic [5:0] duty_pixel_q, request_pixel_q;
	logic [4:0] speed_pixel_q;
	logic [2:0] tilt_column_q, tilt_row_q;
	logic [1:0] duty_colour_q;

	logic          accept;
	logic [TW-1:0] gap, since_upd, period_nxt;
	logic          upd;
	logic signed [16:0] yaw_x, lim_x;
	logic          yaw_big;

	psr_pkg::psr_div_req_t div_req;
	psr_pkg::psr_div_res_t div_res;

	logic [QW-1:0] speed;
	logic          rem_nz;
	logic [7:0]    target;
	logic          slow, above_t, below_t, adj;
	logic [TW-1:0] interval, since_adj;
	logic [7:0]    duty_nxt;
	logic          corr;
	logic          load_out;
	logic [15:0]   pix_prod;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Pulse gap, stall and update tests on the current tick
	assign gap       = now_q - last_pulse_q;
	assign since_upd = now_q - last_upd_q;
	assign upd       = since_upd > {{(TW-CW){1'b0}}, upd_period_q};

	always_comb begin
		period_nxt = period_q;
		if (pulse_seen) begin
			if (gap > {{(TW-CW){1'b0}}, min_gap_q})
				period_nxt = gap;
		end else if (gap > {{(TW-CW){1'b0}}, stall_q}) begin
			period_nxt = '0;
		end
	end

	// Yaw magnitude test against the limit
	assign yaw_x   = {yaw_rate[15], yaw_rate};
	assign lim_x   = {2'b00, gyro_lim_q};
	assign yaw_big = (yaw_x > lim_x) || (yaw_x < -lim_x);

	// Start the speed divide on the period left by this tick
	assign div_req.start   = accept && upd;
	assign div_req.divisor = period_nxt;

	psr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// Speed comparisons from quotient and remainder, no multiply
	assign speed    = per_zero_q ? '0 : div_res.quo;
	assign rem_nz   = per_zero_q ? 1'b0 : div_res.rem_nz;
	assign target   = {1'b0, req_q[7:1]} + 8'd64;
	assign slow     = speed < QW'(20);
	assign above_t  = (speed > {{(QW-8){1'b0}}, target}) ||
		((speed == {{(QW-8){1'b0}}, target}) && rem_nz);
	assign below_t  = speed < {{(QW-8){1'b0}}, target};
	assign interval = {{(TW-CW){1'b0}}, slow ? slow_iv_q : fast_iv_q};
	assign since_adj = cur_q - last_adj_q;
	assign adj      = since_adj > interval;

	// Step the duty
	always_comb begin
		duty_nxt = duty_q;
		corr     = 1'b0;
		if (adj) begin
			if (yaw_big_q) begin
				duty_nxt = (duty_q >= 8'd4) ? duty_q - 8'd4 : 8'd0;
				corr     = 1'b1;
			end else if (above_t) begin
				duty_nxt = (duty_q >= 8'd2) ? duty_q - 8'd2 : 8'd0;
			end else if (below_t) begin
				duty_nxt = (duty_q >= 8'd252) ? 8'd255 : duty_q + 8'd4;
			end
		end
	end

	// Speed / 20 as (speed / 4) * 205 / 1024, saturating once it passes 31
	assign pix_prod = {8'b0, speed[9:2]} * 16'd205;
	assign load_out = (state_q == ST_FIN) && !(out_valid_q && out_stall);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept && upd) state_q <= ST_DIV;
				ST_DIV:  if (div_res.done) state_q <= ST_FIN;
				ST_FIN:  if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q    <= psr_pkg::RST_MIN_GAP;
			stall_q      <= psr_pkg::RST_STALL;
			upd_period_q <= psr_pkg::RST_UPDATE;
			gyro_lim_q   <= psr_pkg::RST_GYRO_LIM;
			slow_iv_q    <= psr_pkg::RST_SLOW_IV;
			fast_iv_q    <= psr_pkg::RST_FAST_IV;
		end else if (cfg_write) begin
			case (cfg_index)
				psr_pkg::REG_MIN_GAP:  min_gap_q    <= cfg_data;
				psr_pkg::REG_STALL:    stall_q      <= cfg_data;
				psr_pkg::REG_UPDATE:   upd_period_q <= cfg_data;
				psr_pkg::REG_GYRO_LIM: gyro_lim_q   <= cfg_data[psr_pkg::GYRO_W-1:0];
				psr_pkg::REG_SLOW_IV:  slow_iv_q    <= cfg_data;
				psr_pkg::REG_FAST_IV:  fast_iv_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance time, track pulses, take the update and adjust stamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			last_pulse_q <= '0;
			period_q     <= '0;
			last_upd_q   <= '0;
			last_adj_q   <= '0;
			duty_q       <= '0;
		end else begin
			if (accept) begin
				now_q    <= now_q + 1'b1;
				period_q <= period_nxt;
				if (pulse_seen) last_pulse_q <= now_q;
				if (upd) last_upd_q <= now_q;
			end
			if (load_out) begin
				duty_q <= duty_nxt;
				if (adj) last_adj_q <= cur_q;
			end
		end
	end

	// Capture the tick for the update
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q      <= now_q;
			req_q      <= pot_sample[9:2];
			pitch_q    <= pitch_rate;
			yaw_q      <= yaw_rate;
			yaw_big_q  <= yaw_big;
			per_zero_q <= (period_nxt == '0);
		end
	end

	// Output valid: set on load, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			pwm_duty_q        <= duty_nxt;
			speed_units_q     <= (speed > QW'(511)) ? 9'h1FF : speed[8:0];
			request_level_q   <= req_q;
			target_speed_q    <= target;
			gyro_correcting_q <= corr;
			duty_pixel_q      <= duty_nxt[7:2];
			speed_pixel_q     <= (speed >= QW'(620)) ? 5'd31 : pix_prod[14:10];
			request_pixel_q   <= req_q[7:2];
			tilt_column_q     <= tilt_of(pitch_q);
			tilt_row_q        <= tilt_of(yaw_q);
			if (corr)
				duty_colour_q <= COL_GYRO;
			else if (duty_nxt == 8'd255 && below_t)
				duty_colour_q <= COL_FULL;
			else
				duty_colour_q <= COL_RED;
		end
	end

	assign out_valid       = out_valid_q;
	assign pwm_duty        = pwm_duty_q;
	assign speed_units     = speed_units_q;
	assign request_level   = request_level_q;
	assign target_speed    = target_speed_q;
	assign gyro_correcting = gyro_correcting_q;
	assign duty_pixel      = duty_pixel_q;
	assign speed_pixel     = speed_pixel_q;
	assign request_pixel   = request_pixel_q;
	assign tilt_column     = tilt_column_q;
	assign tilt_row        = tilt_row_q;
	assign duty_colour     = duty_colour_q;

`ifndef SYNTH
	// The divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider done outside divide wait");

	// A tick that triggers an update blocks the input on the next cycle
	a_upd_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && upd) |=> in_stall)
		else $error("input not blocked after update tick");

	// A busy output register keeps the finish step waiting
	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> state_q == ST_FIN)
		else $error("finish step overran a held beat");

	// A yaw correction always shows its colour
	a_corr_colour: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && gyro_correcting_q) |-> duty_colour_q == COL_GYRO)
		else $error("gyro correction without its colour");
`endif

endmodule

### design/psr_div.sv
// Restoring divider: SPEED_NUM / divisor, one quotient bit per cycle.
module psr_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psr_pkg::psr_div_req_t req,
	output psr_pkg::psr_div_res_t res
);

	logic                              busy_q;
	logic                              done_q;
	logic [psr_pkg::CNT_W-1:0]         cnt_q;
	logic [psr_pkg::NUM_W-1:0]         num_q;
	logic [psr_pkg::NUM_W-1:0]         rem_q;
	logic [psr_pkg::QUO_W-1:0]         quo_q;
	logic [psr_pkg::TIME_W-1:0]        div_q;
	logic [psr_pkg::NUM_W:0]           trial;
	logic [psr_pkg::NUM_W:0]           diff;
	logic                              fits;

	// Trial subtract of the shifted remainder; a divisor with high bits set never fits
	assign trial = {rem_q, num_q[psr_pkg::NUM_W-1]};
	assign diff  = trial - div_q[psr_pkg::NUM_W:0];
	assign fits  = (div_q[psr_pkg::TIME_W-1:psr_pkg::NUM_W+1] == '0) &&
		(trial >= div_q[psr_pkg::NUM_W:0]);

	// Control: load on start, count down the steps, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= psr_pkg::CNT_W'(psr_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == psr_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift one dividend bit in and one quotient bit out per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divisor;
			num_q <= psr_pkg::SPEED_NUM;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[psr_pkg::NUM_W-2:0], 1'b0};
			rem_q <= fits ? diff[psr_pkg::NUM_W-1:0] : trial[psr_pkg::NUM_W-1:0];
			quo_q <= {quo_q[psr_pkg::QUO_W-2:0], fits};
		end
	end

	assign res.done   = done_q;
	assign res.quo    = quo_q;
	assign res.rem_nz = (rem_q != '0);

endmodule
